/* hdl/wmf_pkg.sv */
// Shared types and constants for the window median filter.
package wmf_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HALF  = 3;
  localparam int PIXEL_BITS    = 8;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int QUEUE_DEPTH   = 16;

  localparam int W_CFG_BITS    = 11;
  localparam int H_CFG_BITS    = 13;
  localparam int HALF_CFG_BITS = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 2;

  localparam logic [W_CFG_BITS-1:0]    RST_WIDTH  = 11'd640;
  localparam logic [H_CFG_BITS-1:0]    RST_HEIGHT = 13'd480;
  localparam logic [HALF_CFG_BITS-1:0] RST_HALF   = 2'd1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_HALF   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  is_border;
    logic                  frame_last;
    logic                  config_error;
  } wmf_result_t;

  typedef struct packed {
    logic        valid;
    logic        use_median;
    wmf_result_t res;
  } wmf_tag_t;

endpackage

/* hdl/wmf_in_if.sv */
// Input pixel stream channel.
interface wmf_in_if
  import wmf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, mode, pixel_in, input ready);
  modport sink   (input valid, mode, pixel_in, output ready);
endinterface

/* hdl/wmf_out_if.sv */
// Result pixel stream channel.
interface wmf_out_if
  import wmf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  is_border;
  logic                  frame_last;
  logic                  config_error;

  modport source (output valid, pixel_out, is_border, frame_last, config_error, input ready);
  modport sink   (input valid, pixel_out, is_border, frame_last, config_error, output ready);
endinterface

/* hdl/window_median_filter_top.sv */
// Window median filter: pixels in raster order in, filtered pixels out.
//
// in_bus carries one beat per pixel (mode 0) or flush request (mode 1); a beat
// moves when valid and ready are both high. out_bus returns the results in
// order with the same handshake. The config port writes width, height and
// half window on cfg_we; each write to one of them restarts the frame.
// Result n belongs to pixel n - (h*width + h); after the last pixel, send
// flush beats to drain the rest. The last result of a frame has frame_last.
// Throughput: one beat per cycle while in_bus.ready is high. A result passes
// the line store read, the window shift, one median stage per pixel bit and
// the queue on its way from its input beat to out_bus.
// A 16-entry result queue sits behind the pipeline; in_bus.ready drops when
// every queue slot is claimed, so a stalled receiver back-pressures the
// input without loss. Line store rows are 2*MAX_HALF banks of MAX_WIDTH.
// Reset (rst_n low, synchronous) loads width 640, height 480, h 1 and
// empties the pipeline and queue; line store contents are left as they are.
module window_median_filter_top
  import wmf_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HALF  = DEF_MAX_HALF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wmf_in_if.sink                in_bus,
  wmf_out_if.source             out_bus
);

  localparam int WSIDE = 2 * MAX_HALF + 1;
  localparam int WIN   = WSIDE * WSIDE;

  logic                          in_accept;
  logic                          produce;
  logic                          room;
  logic [PIXEL_BITS-1:0]         win [WIN];
  logic [$clog2(MAX_HALF+1)-1:0] half;
  wmf_tag_t                      tag;
  logic                          push;
  wmf_result_t                   push_data;
  logic                          pop;
  wmf_result_t                   out_data;

  assign in_bus.ready = room;
  assign in_accept    = in_bus.valid & room;
  assign pop          = out_bus.valid & out_bus.ready;

  wmf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_accept  (in_accept),
    .in_mode    (in_bus.mode),
    .in_pixel   (in_bus.pixel_in),
    .in_produce (produce),
    .win_o      (win),
    .half_o     (half),
    .tag_o      (tag)
  );

  wmf_median #(
    .MAX_HALF (MAX_HALF)
  ) u_median (
    .clk    (clk),
    .rst_n  (rst_n),
    .win_i  (win),
    .half_i (half),
    .tag_i  (tag),
    .push_o (push),
    .res_o  (push_data)
  );

  wmf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (produce),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .room      (room),
    .out_valid (out_bus.valid),
    .out_data  (out_data)
  );

  assign out_bus.pixel_out    = out_data.pixel;
  assign out_bus.is_border    = out_data.is_border;
  assign out_bus.frame_last   = out_data.frame_last;
  assign out_bus.config_error = out_data.config_error;

endmodule

/* hdl/wmf_front.sv */
// Front end: configuration, frame counters, line store and window registers.
module wmf_front
  import wmf_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HALF  = DEF_MAX_HALF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_accept,
  input  logic                   in_mode,
  input  logic [PIXEL_BITS-1:0]  in_pixel,
  output logic                   in_produce,
  output logic [PIXEL_BITS-1:0]  win_o [(2*MAX_HALF+1)*(2*MAX_HALF+1)],
  output logic [$clog2(MAX_HALF+1)-1:0] half_o,
  output wmf_tag_t               tag_o
);

  localparam int SLOTS  = 2 * MAX_HALF;
  localparam int WSIDE  = 2 * MAX_HALF + 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
  localparam int CNT_W  = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int HALF_W = $clog2(MAX_HALF + 1);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int EH_W   = $clog2(HEIGHT_LIMIT + 1);
  localparam int CMP_W  = CNT_W + 1;

  // configuration
  logic [W_CFG_BITS-1:0]    wid_r, wid_nxt;
  logic [H_CFG_BITS-1:0]    hgt_r, hgt_nxt;
  logic [HALF_CFG_BITS-1:0] hlf_r, hlf_nxt;
  logic [EW_W-1:0]          effw_r, effw_nxt;
  logic [EH_W-1:0]          effh_r, effh_nxt;
  logic [HALF_W-1:0]        effhalf_r, effhalf_nxt;
  logic [CNT_W-1:0]         total_r, total_nxt;
  logic [CNT_W-1:0]         lat_r, lat_nxt;
  logic                     err_r, err_nxt;
  logic                     cfg_restart;

  always_comb begin : cfg_comb
    int ew;
    int eh;
    int eb;
    int sd;
    wid_nxt     = wid_r;
    hgt_nxt     = hgt_r;
    hlf_nxt     = hlf_r;
    cfg_restart = 1'b0;
    if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH: begin
          wid_nxt     = cfg_data[W_CFG_BITS-1:0];
          cfg_restart = 1'b1;
        end
        REG_HEIGHT: begin
          hgt_nxt     = cfg_data[H_CFG_BITS-1:0];
          cfg_restart = 1'b1;
        end
        REG_HALF: begin
          hlf_nxt     = cfg_data[HALF_CFG_BITS-1:0];
          cfg_restart = 1'b1;
        end
        default: ;
      endcase
    end
    if (!rst_n) begin
      wid_nxt = RST_WIDTH;
      hgt_nxt = RST_HEIGHT;
      hlf_nxt = RST_HALF;
    end
    ew = (wid_nxt == '0) ? 1 : ((int'(wid_nxt) > MAX_WIDTH) ? MAX_WIDTH : int'(wid_nxt));
    eh = (hgt_nxt == '0) ? 1 :
         ((int'(hgt_nxt) > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(hgt_nxt));
    eb = (int'(hlf_nxt) > MAX_HALF) ? MAX_HALF : int'(hlf_nxt);
    sd = 2 * eb + 1;
    effw_nxt    = EW_W'(ew);
    effh_nxt    = EH_W'(eh);
    effhalf_nxt = HALF_W'(eb);
    total_nxt   = CNT_W'(ew * eh);
    lat_nxt     = CNT_W'(eb * ew + eb);
    err_nxt     = (sd > ew) || (sd > eh);
  end

  always_ff @(posedge clk) begin
    wid_r     <= wid_nxt;
    hgt_r     <= hgt_nxt;
    hlf_r     <= hlf_nxt;
    effw_r    <= effw_nxt;
    effh_r    <= effh_nxt;
    effhalf_r <= effhalf_nxt;
    total_r   <= total_nxt;
    lat_r     <= lat_nxt;
    err_r     <= err_nxt;
  end

  // frame counters
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [SLOT_W-1:0] cslot_r, cslot_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  e_r, e_nxt;
  logic [COL_W-1:0]  pcol_r, pcol_nxt;
  logic [ROW_W-1:0]  prow_r, prow_nxt;
  logic [SLOT_W-1:0] pslot_r, pslot_nxt;
  logic              full_r, full_nxt;

  logic     is_flush, n_last, e_last, col_end, pcol_end, interior;
  logic     adv_in, set_full, adv_e, restart;
  logic     wr_en, shift_a, src_mem_a;
  wmf_tag_t tag_a;

  assign is_flush = (in_mode == MODE_FLUSH);
  assign n_last   = (CMP_W'(n_r) + CMP_W'(1)) >= CMP_W'(total_r);
  assign e_last   = (CMP_W'(e_r) + CMP_W'(1)) >= CMP_W'(total_r);
  assign col_end  = (CMP_W'(col_r) + CMP_W'(1)) >= CMP_W'(effw_r);
  assign pcol_end = (CMP_W'(pcol_r) + CMP_W'(1)) >= CMP_W'(effw_r);
  assign interior = (CMP_W'(prow_r) >= CMP_W'(effhalf_r)) &&
                    ((CMP_W'(prow_r) + CMP_W'(effhalf_r)) < CMP_W'(effh_r)) &&
                    (CMP_W'(pcol_r) >= CMP_W'(effhalf_r)) &&
                    ((CMP_W'(pcol_r) + CMP_W'(effhalf_r)) < CMP_W'(effw_r));

  always_comb begin
    adv_in    = 1'b0;
    set_full  = 1'b0;
    adv_e     = 1'b0;
    restart   = 1'b0;
    wr_en     = 1'b0;
    shift_a   = 1'b0;
    src_mem_a = 1'b0;
    tag_a     = '0;
    tag_a.res.pixel = in_pixel;
    if (in_accept) begin
      if (err_r) begin
        if (!is_flush) begin
          tag_a.valid            = 1'b1;
          tag_a.res.is_border    = 1'b1;
          tag_a.res.config_error = 1'b1;
          tag_a.res.frame_last   = n_last;
          restart                = n_last;
          adv_in                 = !n_last;
        end
      end else if (is_flush) begin
        if (full_r) begin
          tag_a.valid          = 1'b1;
          src_mem_a            = 1'b1;
          tag_a.res.is_border  = 1'b1;
          tag_a.res.frame_last = e_last;
          adv_e                = 1'b1;
          restart              = e_last;
        end
      end else if (!full_r) begin
        shift_a  = 1'b1;
        wr_en    = 1'b1;
        set_full = n_last;
        adv_in   = !n_last;
        if (n_r >= lat_r) begin
          tag_a.valid          = 1'b1;
          tag_a.use_median     = interior;
          src_mem_a            = !interior;
          tag_a.res.is_border  = !interior;
          tag_a.res.frame_last = e_last;
          adv_e                = 1'b1;
          restart              = e_last;
        end
      end
    end
  end

  assign in_produce = tag_a.valid;

  always_comb begin
    col_nxt   = col_r;
    cslot_nxt = cslot_r;
    n_nxt     = n_r;
    e_nxt     = e_r;
    pcol_nxt  = pcol_r;
    prow_nxt  = prow_r;
    pslot_nxt = pslot_r;
    full_nxt  = full_r;
    if (adv_in) begin
      n_nxt = n_r + 1'b1;
      if (col_end) begin
        col_nxt   = '0;
        cslot_nxt = (cslot_r == SLOT_W'(SLOTS - 1)) ? '0 : cslot_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (set_full) begin
      full_nxt = 1'b1;
    end
    if (adv_e) begin
      e_nxt = e_r + 1'b1;
      if (pcol_end) begin
        pcol_nxt  = '0;
        prow_nxt  = prow_r + 1'b1;
        pslot_nxt = (pslot_r == SLOT_W'(SLOTS - 1)) ? '0 : pslot_r + 1'b1;
      end else begin
        pcol_nxt = pcol_r + 1'b1;
      end
    end
    if (restart || cfg_restart || !rst_n) begin
      col_nxt   = '0;
      cslot_nxt = '0;
      n_nxt     = '0;
      e_nxt     = '0;
      pcol_nxt  = '0;
      prow_nxt  = '0;
      pslot_nxt = '0;
      full_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    col_r   <= col_nxt;
    cslot_r <= cslot_nxt;
    n_r     <= n_nxt;
    e_r     <= e_nxt;
    pcol_r  <= pcol_nxt;
    prow_r  <= prow_nxt;
    pslot_r <= pslot_nxt;
    full_r  <= full_nxt;
  end

  // line store: one bank per buffered row, read before write at the same edge
  logic [PIXEL_BITS-1:0] line_mem [SLOTS][MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd_col [SLOTS];
  logic [PIXEL_BITS-1:0] rd_bdr [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[cslot_r][col_r] <= in_pixel;
    end
    for (int s = 0; s < SLOTS; s++) begin
      rd_col[s] <= line_mem[s][col_r];
      rd_bdr[s] <= line_mem[s][pcol_r];
    end
  end

  // stage 1: memory data arrives
  wmf_tag_t              s1_tag_r;
  logic                  s1_shift_r;
  logic                  s1_src_mem_r;
  logic [SLOT_W-1:0]     s1_cslot_r;
  logic [SLOT_W-1:0]     s1_pslot_r;
  logic [PIXEL_BITS-1:0] s1_px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.valid <= 1'b0;
      s1_shift_r     <= 1'b0;
    end else begin
      s1_tag_r.valid <= tag_a.valid;
      s1_shift_r     <= shift_a;
    end
    s1_tag_r.use_median <= tag_a.use_median;
    s1_tag_r.res        <= tag_a.res;
    s1_src_mem_r        <= src_mem_a;
    s1_cslot_r          <= cslot_r;
    s1_pslot_r          <= pslot_r;
    s1_px_r             <= in_pixel;
  end

  // newest window column: bottom row is the new pixel, rows above go back in time
  logic [PIXEL_BITS-1:0] col_new [WSIDE];

  always_comb begin : col_map
    int sl;
    col_new[WSIDE-1] = s1_px_r;
    for (int d = 1; d < WSIDE; d++) begin
      sl = int'(s1_cslot_r) + SLOTS - d;
      if (sl >= SLOTS) begin
        sl = sl - SLOTS;
      end
      col_new[WSIDE-1-d] = rd_col[SLOT_W'(sl)];
    end
  end

  logic [PIXEL_BITS-1:0] win_r [WSIDE][WSIDE];

  always_ff @(posedge clk) begin
    if (s1_shift_r) begin
      for (int i = 0; i < WSIDE; i++) begin
        for (int j = 0; j < WSIDE - 1; j++) begin
          win_r[i][j] <= win_r[i][j+1];
        end
        win_r[i][WSIDE-1] <= col_new[i];
      end
    end
  end

  // stage 2: window holds this item's neighborhood
  wmf_tag_t s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r.valid <= 1'b0;
    end else begin
      s2_tag_r.valid <= s1_tag_r.valid;
    end
    s2_tag_r.use_median       <= s1_tag_r.use_median;
    s2_tag_r.res.is_border    <= s1_tag_r.res.is_border;
    s2_tag_r.res.frame_last   <= s1_tag_r.res.frame_last;
    s2_tag_r.res.config_error <= s1_tag_r.res.config_error;
    s2_tag_r.res.pixel        <= s1_src_mem_r ? rd_bdr[s1_pslot_r] : s1_tag_r.res.pixel;
  end

  always_comb begin
    for (int i = 0; i < WSIDE; i++) begin
      for (int j = 0; j < WSIDE; j++) begin
        win_o[i*WSIDE + j] = win_r[i][j];
      end
    end
  end

  assign half_o = effhalf_r;
  assign tag_o  = s2_tag_r;

endmodule

/* hdl/wmf_median.sv */
// Median select: one pipeline stage per pixel bit, MSB first, by rank counting.
module wmf_median
  import wmf_pkg::*;
#(
  parameter int MAX_HALF = DEF_MAX_HALF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [PIXEL_BITS-1:0] win_i [(2*MAX_HALF+1)*(2*MAX_HALF+1)],
  input  logic [$clog2(MAX_HALF+1)-1:0] half_i,
  input  wmf_tag_t              tag_i,
  output logic                  push_o,
  output wmf_result_t           res_o
);

  localparam int WSIDE = 2 * MAX_HALF + 1;
  localparam int WIN   = WSIDE * WSIDE;
  localparam int CW    = $clog2(WIN + 1);

  logic [WIN-1:0] act0;
  logic [CW-1:0]  k0;

  always_comb begin : first_mask
    int off;
    int sd;
    off = 2 * (MAX_HALF - int'(half_i));
    sd  = 2 * int'(half_i) + 1;
    for (int i = 0; i < WSIDE; i++) begin
      for (int j = 0; j < WSIDE; j++) begin
        act0[i*WSIDE + j] = (i >= off) && (j >= off);
      end
    end
    k0 = CW'((sd * sd) >> 1);
  end

  logic [PIXEL_BITS-1:0] vals_r [PIXEL_BITS][WIN];
  logic [WIN-1:0]        act_r  [PIXEL_BITS];
  logic [CW-1:0]         k_r    [PIXEL_BITS];
  logic [PIXEL_BITS-1:0] med_r  [PIXEL_BITS];
  wmf_tag_t              tag_r  [PIXEL_BITS];

  for (genvar s = 0; s < PIXEL_BITS; s++) begin : g_stage
    localparam int BIT = PIXEL_BITS - 1 - s;
    logic [PIXEL_BITS-1:0] cv [WIN];
    logic [WIN-1:0]        ca;
    logic [CW-1:0]         ck;
    logic [PIXEL_BITS-1:0] cm;
    wmf_tag_t              ct;
    logic [WIN-1:0]        zmask;
    logic [CW-1:0]         zeros;
    logic [PIXEL_BITS-1:0] med_one;

    if (s == 0) begin : g_first
      assign cv = win_i;
      assign ca = act0;
      assign ck = k0;
      assign cm = '0;
      assign ct = tag_i;
    end else begin : g_next
      assign cv = vals_r[s-1];
      assign ca = act_r[s-1];
      assign ck = k_r[s-1];
      assign cm = med_r[s-1];
      assign ct = tag_r[s-1];
    end

    always_comb begin : count_zeros
      int z;
      z = 0;
      for (int i = 0; i < WIN; i++) begin
        zmask[i] = ca[i] & ~cv[i][BIT];
        z = z + int'(zmask[i]);
      end
      zeros = CW'(z);
      med_one = cm;
      med_one[BIT] = 1'b1;
    end

    // keep the half that holds the wanted rank
    always_ff @(posedge clk) begin
      vals_r[s] <= cv;
      if (ck < zeros) begin
        act_r[s] <= zmask;
        k_r[s]   <= ck;
        med_r[s] <= cm;
      end else begin
        act_r[s] <= ca & ~zmask;
        k_r[s]   <= ck - zeros;
        med_r[s] <= med_one;
      end
      tag_r[s].use_median <= ct.use_median;
      tag_r[s].res        <= ct.res;
      if (!rst_n) begin
        tag_r[s].valid <= 1'b0;
      end else begin
        tag_r[s].valid <= ct.valid;
      end
    end
  end

  always_comb begin
    push_o = tag_r[PIXEL_BITS-1].valid;
    res_o  = tag_r[PIXEL_BITS-1].res;
    if (tag_r[PIXEL_BITS-1].use_median) begin
      res_o.pixel = med_r[PIXEL_BITS-1];
    end
  end

endmodule

/* hdl/wmf_queue.sv */
// Result queue with slot reservation at input accept.
module wmf_queue
  import wmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        reserve,
  input  logic        push,
  input  wmf_result_t push_data,
  input  logic        pop,
  output logic        room,
  output logic        out_valid,
  output wmf_result_t out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  wmf_result_t      q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] credit_r, credit_nxt;

  assign out_valid = (fill_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign room      = (credit_r < CNT_W'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    credit_nxt = credit_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
    // a slot is held from the input beat until its result leaves
    case ({reserve, pop})
      2'b10:   credit_nxt = credit_r + 1'b1;
      2'b01:   credit_nxt = credit_r - 1'b1;
      default: credit_nxt = credit_r;
    endcase
    if (!rst_n) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      fill_nxt   = '0;
      credit_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    wr_ptr_r <= wr_ptr_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    fill_r   <= fill_nxt;
    credit_r <= credit_nxt;
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
